// ===== design/cdr_pkg.sv =====
// cdr_pkg: shared constants and types for the circular record deque
// depends on nothing; imported by cdr_store, circular_deque_records and tb_top

package cdr_pkg;

   localparam int DEPTH     = 16;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_W     = 5;
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;
   localparam int ACTION_W  = 3;
   localparam int STATUS_W  = 2;
   localparam int DATA_W    = 16;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LIST_FWD   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_LIST_BWD   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] roll;
      logic [DATA_W-1:0] total;
   } cdr_wr_type;

endpackage

// ===== design/cdr_store.sv =====
// cdr_store: record memory, one write port and one registered read port
// depends on cdr_pkg

module cdr_store (
   input  logic                       clock,
   input  cdr_pkg::cdr_wr_type        wr,
   input  logic [cdr_pkg::IDX_W-1:0]  rd_addr,
   output logic [cdr_pkg::DATA_W-1:0] rd_roll,
   output logic [cdr_pkg::DATA_W-1:0] rd_total
);
   import cdr_pkg::*;

   logic [DATA_W-1:0] roll_mem  [DEPTH];
   logic [DATA_W-1:0] total_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         roll_mem[wr.addr]  <= wr.roll;
         total_mem[wr.addr] <= wr.total;
      end
      rd_roll  <= roll_mem[rd_addr];
      rd_total <= total_mem[rd_addr];
   end

endmodule

// ===== design/circular_deque_records.sv =====
// circular_deque_records: double-ended queue of (roll, total) records in a circular
// store whose size in use is csr_capacity (1..16, clamped; writing it empties the
// queue). One item is worked at a time. A push or pop passes through an execute state
// and then holds its registered result, and the next request is taken once the result
// has transferred. A listing gives one result per stored entry, each going through a
// memory read state, a load state and its transfer before the next entry is read.
// All index moves go through one shared wrap-around step unit.
// depends on cdr_pkg and cdr_store

module circular_deque_records (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [cdr_pkg::ACTION_W-1:0] req_action,
   input  logic [cdr_pkg::DATA_W-1:0]   req_roll_number,
   input  logic [cdr_pkg::DATA_W-1:0]   req_total_score,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cdr_pkg::STATUS_W-1:0] rsp_status,
   output logic [cdr_pkg::DATA_W-1:0]   rsp_entry_roll,
   output logic [cdr_pkg::DATA_W-1:0]   rsp_entry_total,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cdr_pkg::CAP_W-1:0]    csr_capacity
);
   import cdr_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_LIST, S_DRAIN} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   cursor_ff, cursor_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [DATA_W-1:0]  roll_ff, roll_in;
   logic [DATA_W-1:0]  total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_roll_ff, rsp_roll_in;
   logic [DATA_W-1:0]  rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff, rsp_last_in;

   cdr_wr_type         wr;
   logic [DATA_W-1:0]  rd_roll, rd_total;

   // shared step unit
   logic [IDX_W-1:0]   step_idx, step_out;
   logic               step_up;
   logic [CMP_W-1:0]   cfg_ext;

   logic req_xfer, rsp_xfer, csr_xfer;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff || csr_valid;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_xfer  = csr_valid && csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_roll  = rsp_roll_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

   cdr_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (cursor_ff),
      .rd_roll  (rd_roll),
      .rd_total (rd_total)
   );

   always_comb begin
      if (step_up) begin
         step_out = ((CNT_W'(step_idx) + CNT_W'(1)) >= cap_ff) ? '0 : step_idx + IDX_W'(1);
      end else begin
         step_out = (step_idx == '0) ? IDX_W'(cap_ff - CNT_W'(1)) : step_idx - IDX_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      occ_in        = occ_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      remain_in     = remain_ff;
      act_in        = act_ff;
      roll_in       = roll_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_roll_in   = rsp_roll_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      wr            = '0;
      step_idx      = cursor_ff;
      step_up       = 1'b1;
      cfg_ext       = CMP_W'(csr_capacity);

      case (state_ff)
         S_IDLE: begin
            if (csr_xfer) begin
               if (cfg_ext == '0) begin
                  cap_in = CNT_W'(1);
               end else if (cfg_ext > CMP_W'(DEPTH)) begin
                  cap_in = CNT_W'(DEPTH);
               end else begin
                  cap_in = CNT_W'(cfg_ext);
               end
               occ_in  = '0;
               head_in = '0;
               tail_in = '0;
            end
            if (req_xfer) begin
               act_in   = req_action;
               roll_in  = req_roll_number;
               total_in = req_total_score;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // single-result actions land here by default
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_roll_in   = '0;
            rsp_total_in  = '0;
            rsp_last_in   = 1'b1;
            remain_in     = '0;
            state_in      = S_DRAIN;
            case (act_ff)
               ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                  step_up  = (act_ff == ACT_PUSH_REAR);
                  step_idx = step_up ? tail_ff : head_ff;
                  if (occ_ff >= cap_ff) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr.en    = 1'b1;
                     wr.roll  = roll_ff;
                     wr.total = total_ff;
                     occ_in   = occ_ff + CNT_W'(1);
                     if (occ_ff == '0) begin
                        wr.addr = '0;
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        wr.addr = step_out;
                        if (step_up) begin
                           tail_in = step_out;
                        end else begin
                           head_in = step_out;
                        end
                     end
                  end
               end
               ACT_POP_FRONT, ACT_POP_REAR: begin
                  step_up  = (act_ff == ACT_POP_FRONT);
                  step_idx = step_up ? head_ff : tail_ff;
                  if (occ_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     occ_in = occ_ff - CNT_W'(1);
                     if (occ_ff == CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (step_up) begin
                        head_in = step_out;
                     end else begin
                        tail_in = step_out;
                     end
                  end
               end
               ACT_LIST_FWD, ACT_LIST_BWD: begin
                  if (occ_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     cursor_in    = (act_ff == ACT_LIST_FWD) ? head_ff : tail_ff;
                     remain_in    = occ_ff;
                     state_in     = S_READ;
                  end
               end
               default: begin
                  // unused codes give no result
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            state_in = S_LIST;
         end
         S_LIST: begin
            step_idx      = cursor_ff;
            step_up       = (act_ff == ACT_LIST_FWD);
            cursor_in     = step_out;
            remain_in     = remain_ff - CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_roll_in   = rd_roll;
            rsp_total_in  = rd_total;
            rsp_last_in   = (remain_ff == CNT_W'(1));
            state_in      = S_DRAIN;
         end
         S_DRAIN: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               state_in     = (remain_ff != '0) ? S_READ : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CNT_W'(CAP_RESET);
         occ_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cursor_ff     <= cursor_in;
      act_ff        <= act_in;
      roll_ff       <= roll_in;
      total_ff      <= total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_roll_ff   <= rsp_roll_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cap_ff)
      else $error("occupancy above capacity");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty queue with nonzero pointers");

   a_last_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_ENTRY |-> rsp_last_ff == (remain_ff == '0))
      else $error("listing last flag out of step with remaining count");

   a_req_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_EXEC)
      else $error("accepted request not executed");

   a_drain_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> rsp_valid_ff)
      else $error("drain state without pending result");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for circular_deque_records, the circular record deque
// keeps its own copy of the deque state, predicts every result and checks each one
// depends on cdr_pkg and circular_deque_records

module tb_top;
   import cdr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int DRAIN_CYCLES = 8;

   // action codes the block ignores
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   roll;
      logic [DATA_W-1:0]   total;
   } deque_request;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   roll;
      logic [DATA_W-1:0]   total;
      logic                last;
   } deque_result;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [DATA_W-1:0]   req_roll_number = '0;
   logic [DATA_W-1:0]   req_total_score = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_entry_roll;
   logic [DATA_W-1:0]   rsp_entry_total;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_capacity = '0;

   deque_request queued_requests[$];
   deque_result  due_records[$];
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   // idle mix and capacity for each phase
   int               sender_pcts[4]   = '{0, 52, 0, 12};
   int               receiver_pcts[4] = '{0, 0, 52, 12};
   logic [CAP_W-1:0] phase_caps[8]    = '{5'd31, 5'd1, 5'd3, 5'd16,
                                          5'd17, 5'd5, 5'd2, 5'd8};

   // predicted deque state
   logic [DATA_W-1:0] model_rolls[DEPTH];
   logic [DATA_W-1:0] model_totals[DEPTH];
   int                model_head = 0;
   int                model_tail = 0;
   int                model_occupancy = 0;
   int                model_capacity = CAP_RESET;

   circular_deque_records DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_roll_number (req_roll_number),
      .req_total_score (req_total_score),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_roll  (rsp_entry_roll),
      .rsp_entry_total (rsp_entry_total),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always #6 clock = ~clock;

   function automatic int wrap_up(input int i);
      return (i + 1 >= model_capacity) ? 0 : i + 1;
   endfunction

   function automatic int wrap_down(input int i);
      return (i == 0) ? model_capacity - 1 : i - 1;
   endfunction

   function automatic void expect_record(input logic [STATUS_W-1:0] status,
                                         input logic [DATA_W-1:0] roll,
                                         input logic [DATA_W-1:0] total,
                                         input logic last);
      deque_result r;
      r.status = status;
      r.roll   = roll;
      r.total  = total;
      r.last   = last;
      due_records.push_back(r);
   endfunction

   // applies one accepted request to the predicted deque and queues its results
   function automatic void model_deque_action(input logic [ACTION_W-1:0] action,
                                              input logic [DATA_W-1:0] roll,
                                              input logic [DATA_W-1:0] total);
      int slot;
      case (action)
         ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            if (model_occupancy >= model_capacity) begin
               expect_record(ST_FULL, '0, '0, 1'b1);
            end else begin
               if (model_occupancy == 0) begin
                  model_head = 0;
                  model_tail = 0;
                  slot = 0;
               end else if (action == ACT_PUSH_FRONT) begin
                  model_head = wrap_down(model_head);
                  slot = model_head;
               end else begin
                  model_tail = wrap_up(model_tail);
                  slot = model_tail;
               end
               model_rolls[IDX_W'(slot)]  = roll;
               model_totals[IDX_W'(slot)] = total;
               model_occupancy++;
               expect_record(ST_DONE, '0, '0, 1'b1);
            end
         end
         ACT_POP_FRONT, ACT_POP_REAR: begin
            if (model_occupancy == 0) begin
               expect_record(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               model_occupancy--;
               if (model_occupancy == 0) begin
                  model_head = 0;
                  model_tail = 0;
               end else if (action == ACT_POP_FRONT) begin
                  model_head = wrap_up(model_head);
               end else begin
                  model_tail = wrap_down(model_tail);
               end
               expect_record(ST_DONE, '0, '0, 1'b1);
            end
         end
         ACT_LIST_FWD, ACT_LIST_BWD: begin
            if (model_occupancy == 0) begin
               expect_record(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               slot = (action == ACT_LIST_FWD) ? model_head : model_tail;
               for (int k = 0; k < model_occupancy; k++) begin
                  expect_record(ST_ENTRY, model_rolls[IDX_W'(slot)],
                                model_totals[IDX_W'(slot)], k + 1 == model_occupancy);
                  slot = (action == ACT_LIST_FWD) ? wrap_up(slot) : wrap_down(slot);
               end
            end
         end
         default: begin
            // unused codes give nothing
         end
      endcase
   endfunction

   function automatic void add_request(input logic [ACTION_W-1:0] action,
                                       input logic [DATA_W-1:0] roll,
                                       input logic [DATA_W-1:0] total);
      deque_request q;
      q.action = action;
      q.roll   = roll;
      q.total  = total;
      queued_requests.push_back(q);
   endfunction

   // bursts that lean toward filling or draining so full and empty both get reached
   function automatic void queue_random_traffic(input int count);
      int  made;
      int  burst;
      int  pick;
      int  push_pct;
      bit  filling;
      made = 0;
      burst = 0;
      filling = 1'b0;
      while (made < count) begin
         if (burst == 0) begin
            filling = ($urandom_range(0, 3) != 0) ? ~filling : filling;
            burst = $urandom_range(2, 2 * model_capacity + 4);
         end
         burst--;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            add_request($urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO,
                        DATA_W'($urandom), DATA_W'($urandom));
         end else begin
            made++;
            push_pct = filling ? 80 : 20;
            if (pick < 18)
               add_request($urandom_range(0, 1) ? ACT_LIST_FWD : ACT_LIST_BWD,
                           DATA_W'($urandom), DATA_W'($urandom));
            else if ($urandom_range(0, 99) < push_pct)
               add_request($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR,
                           DATA_W'($urandom), DATA_W'($urandom));
            else
               add_request($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR,
                           DATA_W'($urandom), DATA_W'($urandom));
         end
      end
   endfunction

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      model_capacity  = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
      model_occupancy = 0;
      model_head      = 0;
      model_tail      = 0;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || due_records.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver: a presented request holds until its transfer
   always @(posedge clock) begin
      deque_request next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            model_deque_action(req_action, req_roll_number, req_total_score);
         if (!req_valid || !req_stall) begin
            if (queued_requests.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               next_req = queued_requests.pop_front();
               req_valid       <= 1'b1;
               req_action      <= next_req.action;
               req_roll_number <= next_req.roll;
               req_total_score <= next_req.total;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      deque_result got;
      deque_result want;
      string       want_txt;
      string       got_txt;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.roll   = rsp_entry_roll;
            got.total  = rsp_entry_total;
            got.last   = rsp_last;
            if (due_records.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result status %0d roll %h total %h last %0d",
                        $realtime, got.status, got.roll, got.total, got.last);
            end else begin
               want = due_records.pop_front();
               if (got.status !== want.status || got.roll !== want.roll ||
                   got.total !== want.total || got.last !== want.last) begin
                  error_count++;
                  want_txt = $sformatf("status %0d roll %h total %h last %0d",
                                       want.status, want.roll, want.total, want.last);
                  got_txt  = $sformatf("status %0d roll %h total %h last %0d",
                                       got.status, got.roll, got.total, got.last);
                  $display("%0t: mismatch expected %s, actual %s",
                           $realtime, want_txt, got_txt);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases, wrap at the front, both listings, unused codes
      add_request(ACT_POP_FRONT, 16'h0000, 16'h0000);
      add_request(ACT_POP_REAR, 16'hffff, 16'hffff);
      add_request(ACT_LIST_FWD, 16'h0000, 16'h0000);
      add_request(ACT_LIST_BWD, 16'h0000, 16'h0000);
      add_request(ACT_PUSH_REAR, 16'h0000, 16'h0000);
      add_request(ACT_PUSH_FRONT, 16'hffff, 16'hffff);
      add_request(ACT_PUSH_REAR, 16'h8000, 16'h0001);
      add_request(ACT_PUSH_FRONT, 16'h0001, 16'h8000);
      add_request(ACT_LIST_FWD, 16'h0000, 16'h0000);
      add_request(ACT_LIST_BWD, 16'h0000, 16'h0000);
      add_request(ACT_UNUSED_LO, 16'h5a5a, 16'ha5a5);
      add_request(ACT_UNUSED_HI, 16'ha5a5, 16'h5a5a);
      add_request(ACT_POP_FRONT, 16'h0000, 16'h0000);
      add_request(ACT_POP_REAR, 16'h0000, 16'h0000);
      add_request(ACT_POP_FRONT, 16'h0000, 16'h0000);
      add_request(ACT_POP_REAR, 16'h0000, 16'h0000);
      add_request(ACT_POP_FRONT, 16'h0000, 16'h0000);
      add_request(ACT_PUSH_FRONT, 16'h1234, 16'h5678);
      wait_drained();

      // zero clamps to one entry; the write also drops the entry left above
      write_capacity(5'd0);
      add_request(ACT_PUSH_REAR, 16'haaaa, 16'h5555);
      add_request(ACT_PUSH_FRONT, 16'h0f0f, 16'hf0f0);
      add_request(ACT_PUSH_REAR, 16'hf0f0, 16'h0f0f);
      add_request(ACT_LIST_BWD, 16'h0000, 16'h0000);
      add_request(ACT_POP_FRONT, 16'h0000, 16'h0000);
      add_request(ACT_LIST_FWD, 16'h0000, 16'h0000);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         write_capacity(phase_caps[phase]);
         sender_idle_pct    = sender_pcts[phase % 4];
         receiver_stall_pct = receiver_pcts[phase % 4];
         queue_random_traffic(ITEMS_PER_PHASE);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (due_records.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $realtime,
                  due_records.size());
      end
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
